/* rtl/orp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// orp_pkg
// Shared types and constants of the radix-8 trie map: op and status codes,
// the controller command word and the datapath status word.
// ----------------------------------------------------------------------------
package orp_pkg;

  localparam int DIGIT_BITS = 3;
  localparam int FANOUT     = 1 << DIGIT_BITS;

  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [31:0] MISS_CODE = 32'h8000_0001;

  // which result the datapath latches
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_MISS,
    RES_FULL,
    RES_FIND
  } res_t;

  typedef struct packed {
    logic load;       // capture key and value, pick the root
    logic advance;    // follow the existing link
    logic alloc;      // link a fresh node into the current row
    logic zero_row;   // wipe links of the node just made
    logic store_val;  // write value at current node
    logic clr;        // wipe a root
    logic clr_idx;    // which root
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic link_ok;
    logic pool_full;
  } sts_t;

endpackage : orp_pkg
`default_nettype wire

/* rtl/octal_radix_trie_map_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// octal_radix_trie_map_unit
// Integer-keyed map held as a radix-8 trie in a fixed node pool; find,
// insert and clear, one result word per command word.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  in       | start, busy      | in_op, in_key, in_entry_value
//  out      | out_valid        | out_read_value, out_status
//
//  A word is taken when start is high and busy low. Each trie level costs a
//  link row read and an evaluation, plus a child row wipe when insert
//  allocates a node. After reset a pass wipes both roots with busy high;
//  allocated nodes are wiped as they are made. out_valid pulses for one
//  cycle and the receiver cannot stall it.
// ----------------------------------------------------------------------------
module octal_radix_trie_map_unit
  import orp_pkg::*;
#(
  parameter int POOL_NODES = 1022
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_op,
  input  wire logic signed [31:0] in_key,
  input  wire logic signed [31:0] in_entry_value,
  output logic                    out_valid,
  output logic signed [31:0]      out_read_value,
  output logic [1:0]              out_status
);

  cmd_t cmd;
  sts_t sts;

  orp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  orp_dp #(
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_key         (in_key),
    .in_entry_value (in_entry_value),
    .sts            (sts),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

`ifndef ASSERT_OFF
  // roots are wiped after reset before any word is taken
  a_reset_wipe: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // a find or insert passes through a link read before answering
  a_walk_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_FIND || in_op == OP_INSERT)) |=> !out_valid)
    else $error("walk answered without a link read");

  a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_MISS) |-> (out_read_value == $signed(MISS_CODE)))
    else $error("miss status without miss code");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_read_value == 32'sd0))
    else $error("pool full result carries a value");
`endif

endmodule : octal_radix_trie_map_unit
`default_nettype wire

/* rtl/orp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// orp_ctrl
// Sequencer of the trie walk: root clearing, per-level link read and
// evaluation, node allocation and result strobe.
// ----------------------------------------------------------------------------
module orp_ctrl
  import orp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_op,
  input  wire sts_t       sts,
  output cmd_t            cmd,
  output logic            busy,
  output logic            out_valid
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_RD,
    S_EV,
    S_ZR,
    S_VAL
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic       clr_cnt_r, clr_cnt_nxt;
  logic       clr_rsp_r, clr_rsp_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_rsp_nxt   = clr_rsp_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.res       = RES_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_op) inside
            OP_FIND, OP_INSERT: begin
              cmd.load  = 1'b1;
              op_nxt    = in_op;
              state_nxt = S_RD;
            end
            OP_CLEAR: begin
              clr_cnt_nxt = 1'b0;
              clr_rsp_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            default: begin
              cmd.res       = RES_OK;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_CLR: begin
        cmd.clr     = 1'b1;
        cmd.clr_idx = clr_cnt_r;
        if (clr_cnt_r) begin
          state_nxt = S_IDLE;
          if (clr_rsp_r) begin
            cmd.res       = RES_OK;
            out_valid_nxt = 1'b1;
          end
        end else begin
          clr_cnt_nxt = 1'b1;
        end
      end
      S_RD: begin
        if (sts.mag_zero) begin
          if (op_r == OP_FIND) begin
            state_nxt = S_VAL;
          end else begin
            cmd.store_val = 1'b1;
            cmd.res       = RES_OK;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          state_nxt = S_EV;
        end
      end
      S_EV: begin
        if (sts.link_ok) begin
          cmd.advance = 1'b1;
          state_nxt   = S_RD;
        end else if (op_r == OP_FIND) begin
          cmd.res       = RES_MISS;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (sts.pool_full) begin
          cmd.res       = RES_FULL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.alloc = 1'b1;
          state_nxt = S_ZR;
        end
      end
      S_ZR: begin
        cmd.zero_row = 1'b1;
        state_nxt    = S_RD;
      end
      S_VAL: begin
        cmd.res       = RES_FIND;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      op_r        <= OP_FIND;
      clr_cnt_r   <= 1'b0;
      clr_rsp_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_rsp_r   <= clr_rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule : orp_ctrl
`default_nettype wire

/* rtl/orp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// orp_dp
// Trie datapath: link row memory (eight links per node), node value memory,
// walk registers, pool allocator and result registers.
// ----------------------------------------------------------------------------
module orp_dp
  import orp_pkg::*;
#(
  parameter int POOL_NODES = 1022
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cmd_t               cmd,
  input  wire logic signed [31:0] in_key,
  input  wire logic signed [31:0] in_entry_value,
  output sts_t                    sts,
  output logic signed [31:0]      out_read_value,
  output logic [1:0]              out_status
);

  localparam int TOTAL = POOL_NODES + 2;
  localparam int NW    = $clog2(TOTAL);
  localparam int CW    = $clog2(TOTAL + 1);
  localparam int ROW_W = FANOUT * NW;

  logic [ROW_W-1:0] link_mem [TOTAL];
  logic [31:0]      val_mem  [TOTAL];

  logic [NW-1:0]         node_r;
  logic [31:0]           mag_r;
  logic [31:0]           val_r;
  logic [CW-1:0]         used_r;
  logic [ROW_W-1:0]      row_q;
  logic [31:0]           val_q;
  logic [31:0]           rv_r;
  logic [1:0]            st_r;

  logic [DIGIT_BITS-1:0] digit;
  logic [NW-1:0]         link;
  logic [ROW_W-1:0]      row_upd;
  logic [NW-1:0]         new_node;
  logic [31:0]           key_u;
  logic [31:0]           key_mag;

  logic                  lk_we;
  logic [NW-1:0]         lk_addr;
  logic [ROW_W-1:0]      lk_wdata;
  logic                  vm_we;
  logic [NW-1:0]         vm_addr;
  logic [31:0]           vm_wdata;

  assign digit    = mag_r[DIGIT_BITS-1:0];
  assign link     = row_q[digit*NW +: NW];
  assign new_node = used_r[NW-1:0];
  assign key_u    = $unsigned(in_key);
  assign key_mag  = key_u[31] ? (32'd0 - key_u) : key_u;

  always_comb begin
    row_upd                    = row_q;
    row_upd[digit*NW +: NW]    = new_node;
  end

  assign sts.mag_zero  = (mag_r == 32'd0);
  assign sts.link_ok   = (link != '0) && (CW'(link) < CW'(TOTAL));
  assign sts.pool_full = (used_r >= CW'(TOTAL));

  // write port select; the controller never raises two of these at once
  always_comb begin
    lk_we    = 1'b0;
    lk_addr  = node_r;
    lk_wdata = '0;
    vm_we    = 1'b0;
    vm_addr  = node_r;
    vm_wdata = '0;
    if (cmd.alloc) begin
      lk_we    = 1'b1;
      lk_wdata = row_upd;
      vm_we    = 1'b1;
      vm_addr  = new_node;
    end else if (cmd.zero_row) begin
      lk_we = 1'b1;
    end else if (cmd.store_val) begin
      vm_we    = 1'b1;
      vm_wdata = val_r;
    end else if (cmd.clr) begin
      lk_we   = 1'b1;
      lk_addr = NW'(cmd.clr_idx);
      vm_we   = 1'b1;
      vm_addr = NW'(cmd.clr_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_addr] <= lk_wdata;
    end
    row_q <= link_mem[node_r];
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      val_mem[vm_addr] <= vm_wdata;
    end
    val_q <= val_mem[node_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= CW'(2);
    end else if (cmd.clr) begin
      used_r <= CW'(2);
    end else if (cmd.alloc) begin
      used_r <= used_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      node_r <= NW'(key_u[31]);
      mag_r  <= key_mag;
      val_r  <= $unsigned(in_entry_value);
    end else if (cmd.advance) begin
      node_r <= link;
      mag_r  <= mag_r >> DIGIT_BITS;
    end else if (cmd.alloc) begin
      node_r <= new_node;
      mag_r  <= mag_r >> DIGIT_BITS;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_OK: begin
        rv_r <= 32'd0;
        st_r <= ST_OK;
      end
      RES_MISS: begin
        rv_r <= MISS_CODE;
        st_r <= ST_MISS;
      end
      RES_FULL: begin
        rv_r <= 32'd0;
        st_r <= ST_FULL;
      end
      RES_FIND: begin
        rv_r <= val_q;
        st_r <= ST_OK;
      end
      default: begin
        rv_r <= rv_r;
        st_r <= st_r;
      end
    endcase
  end

  assign out_read_value = $signed(rv_r);
  assign out_status     = st_r;

endmodule : orp_dp
`default_nettype wire
